### hdl/swmf_pkg.sv
// Package for the sliding window median filter.
// Holds default sizes, the configuration register layout, the controller
// state type and the control bundle sent to the cell chain. No dependencies.
package swmf_pkg;

  // Default sizes for the top level parameters
  localparam int MaxWindowDef   = 15;
  localparam int SampleWidthDef = 16;

  // Window size register
  localparam int CfgWidth = 4;
  localparam logic [CfgWidth-1:0] WindowReset = 4'd5;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_RANK,
    S_MED,
    S_FLUSH
  } state_t;

  // Control bundle broadcast to every cell of the chain
  typedef struct packed {
    logic shift;       // move held samples one cell toward the head
    logic probe_load;  // copy held samples into the probe chain, clear ranks
    logic rank_en;     // count the head probe against the held sample
  } cell_ctrl_t;

endpackage

### hdl/swmf_cell.sv
// One cell of the median filter chain: a held sample, a probe register that
// shifts toward the head, and a rank counter. Depends on swmf_pkg.
module swmf_cell #(
  parameter int INDEX        = 0,
  parameter int SAMPLE_WIDTH = swmf_pkg::SampleWidthDef,
  parameter int CW           = 4
) (
  input  logic                     clk,
  input  swmf_pkg::cell_ctrl_t     ctrl,
  input  logic                     wr_en,
  input  logic [SAMPLE_WIDTH-1:0]  wr_data,
  input  logic [SAMPLE_WIDTH-1:0]  next_value,
  input  logic [SAMPLE_WIDTH-1:0]  next_probe,
  input  logic [SAMPLE_WIDTH-1:0]  head_probe,
  input  logic [CW-1:0]            tick,
  output logic [SAMPLE_WIDTH-1:0]  value,
  output logic [SAMPLE_WIDTH-1:0]  probe,
  output logic [CW-1:0]            rank
);

  logic below;

  // Head probe ranks below this sample; ties go to the older sample
  always_comb begin
    below = ($signed(head_probe) < $signed(value)) ||
            ((head_probe == value) && (int'(tick) < INDEX));
  end

  // Hold, insert or advance the held sample
  always_ff @(posedge clk) begin
    if (wr_en) begin
      value <= wr_data;
    end else if (ctrl.shift) begin
      value <= next_value;
    end
  end

  // Load the probe from the held sample, else advance it toward the head
  always_ff @(posedge clk) begin
    if (ctrl.probe_load) begin
      probe <= wr_en ? wr_data : value;
    end else begin
      probe <= next_probe;
    end
  end

  // Count probes that sort ahead of this sample
  always_ff @(posedge clk) begin
    if (ctrl.probe_load) begin
      rank <= '0;
    end else if (ctrl.rank_en && below) begin
      rank <= rank + CW'(1);
    end
  end

endmodule

### hdl/sliding_window_median_filter_unit.sv
// Sliding window median filter, top level: controller and the cell chain.
// Depends on swmf_pkg and swmf_cell.
//
// Each sample on the input stream is held in a chain of cells, oldest at
// the head. With an odd window W, once W samples are held every new sample
// yields the median of the window (placed at the window's start) and the
// oldest sample leaves the chain. A sample flagged by tlast ends the track:
// after its median, if any, the held samples are sent on unchanged, oldest
// first, and the chain empties. With an even window, or zero, every sample
// passes through unchanged. A sample that yields a median goes through a
// ranking pass in which the probe chain brings one window sample per cycle
// to the head and every cell counts it against its own sample; flushed
// samples then leave the head one by one. Results wait in an output
// register, and the block stalls while it is full. Writing the window size
// empties the chain without results.
module sliding_window_median_filter_unit #(
  parameter int MAX_WINDOW   = swmf_pkg::MaxWindowDef,
  parameter int SAMPLE_WIDTH = swmf_pkg::SampleWidthDef
) (
  input  logic                                clk,
  input  logic                                rst,
  // Window size register
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [swmf_pkg::CfgWidth-1:0]       cfg_data,
  // Sample stream in
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_tdata,  // sample
  input  logic                                s_tlast,  // final_req
  // Result stream out
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   m_tdata,  // value
  output logic                                m_tlast   // end_of_run
);

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int DW = ((SAMPLE_WIDTH + 7) / 8) * 8;

  swmf_pkg::state_t     state, state_next;
  logic [swmf_pkg::CfgWidth-1:0] wsize;
  logic [CW-1:0]        fill, fill_next;
  logic [CW-1:0]        tick, tick_next;
  logic [SAMPLE_WIDTH-1:0] smp;
  logic                 fin;
  logic                 out_valid;
  logic [SAMPLE_WIDTH-1:0] out_value, out_value_next;
  logic                 out_last, out_last_next;
  logic                 out_load;
  logic                 wr_any;
  swmf_pkg::cell_ctrl_t cc;

  logic [CW-1:0]        w_eff, cnt_eff, cnt_inc, mid;
  logic                 odd, slot_free;
  logic [SAMPLE_WIDTH-1:0] median;

  logic [SAMPLE_WIDTH-1:0] cell_value [MAX_WINDOW];
  logic [SAMPLE_WIDTH-1:0] cell_probe [MAX_WINDOW];
  logic [CW-1:0]           cell_rank  [MAX_WINDOW];

  // Handshakes and result port
  assign s_tready  = (state == swmf_pkg::S_IDLE);
  assign cfg_ready = (state == swmf_pkg::S_IDLE);
  assign m_tvalid  = out_valid;
  assign m_tdata   = DW'(out_value);
  assign m_tlast   = out_last;
  assign slot_free = !out_valid || m_tready;

  // Window limits and insert position
  always_comb begin
    w_eff   = CW'((int'(wsize) > MAX_WINDOW) ? MAX_WINDOW : int'(wsize));
    odd     = w_eff[0];
    cnt_eff = (fill >= w_eff) ? (w_eff - CW'(1)) : fill;
    cnt_inc = cnt_eff + CW'(1);
    mid     = (w_eff - CW'(1)) >> 1;
  end

  // Pick the cell whose rank is the middle one
  always_comb begin
    median = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if ((CW'(i) < w_eff) && (cell_rank[i] == mid)) begin
        median = median | cell_value[i];
      end
    end
  end

  // Next state and control
  always_comb begin
    state_next     = state;
    fill_next      = fill;
    tick_next      = tick;
    out_load       = 1'b0;
    out_value_next = smp;
    out_last_next  = 1'b1;
    wr_any         = 1'b0;
    cc             = '0;
    case (state)
      swmf_pkg::S_IDLE: begin
        if (cfg_valid) begin
          fill_next = '0;
        end
        if (s_tvalid) begin
          state_next = swmf_pkg::S_DECIDE;
        end
      end
      swmf_pkg::S_DECIDE: begin
        if (!odd) begin
          if (slot_free) begin
            out_load   = 1'b1;
            fill_next  = '0;
            state_next = swmf_pkg::S_IDLE;
          end
        end else begin
          wr_any    = 1'b1;
          fill_next = cnt_inc;
          if (cnt_inc == w_eff) begin
            cc.probe_load = 1'b1;
            tick_next     = '0;
            state_next    = swmf_pkg::S_RANK;
          end else if (fin) begin
            state_next = swmf_pkg::S_FLUSH;
          end else begin
            state_next = swmf_pkg::S_IDLE;
          end
        end
      end
      swmf_pkg::S_RANK: begin
        cc.rank_en = 1'b1;
        tick_next  = tick + CW'(1);
        if (tick == (w_eff - CW'(1))) begin
          state_next = swmf_pkg::S_MED;
        end
      end
      swmf_pkg::S_MED: begin
        if (slot_free) begin
          out_load       = 1'b1;
          out_value_next = median;
          out_last_next  = !(fin && (w_eff != CW'(1)));
          cc.shift       = 1'b1;
          fill_next      = fill - CW'(1);
          if (fin && (w_eff != CW'(1))) begin
            state_next = swmf_pkg::S_FLUSH;
          end else begin
            if (fin) begin
              fill_next = '0;
            end
            state_next = swmf_pkg::S_IDLE;
          end
        end
      end
      swmf_pkg::S_FLUSH: begin
        if (slot_free) begin
          out_load       = 1'b1;
          out_value_next = cell_value[0];
          out_last_next  = (fill == CW'(1));
          cc.shift       = 1'b1;
          fill_next      = fill - CW'(1);
          if (fill == CW'(1)) begin
            state_next = swmf_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = swmf_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swmf_pkg::S_IDLE;
      wsize <= swmf_pkg::WindowReset;
      fill  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (cfg_valid && cfg_ready) begin
        wsize <= cfg_data;
      end
    end
  end

  // Capture the accepted transaction, advance the rank tick
  always_ff @(posedge clk) begin
    tick <= tick_next;
    if (s_tvalid && s_tready) begin
      smp <= s_tdata[SAMPLE_WIDTH-1:0];
      fin <= s_tlast;
    end
  end

  // Output register: hold until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value <= out_value_next;
      out_last  <= out_last_next;
    end
  end

  // Cell chain, head at index zero
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic [SAMPLE_WIDTH-1:0] nv, np;
    if (i == MAX_WINDOW - 1) begin : g_tail
      assign nv = cell_value[i];
      assign np = cell_probe[i];
    end else begin : g_mid
      assign nv = cell_value[i+1];
      assign np = cell_probe[i+1];
    end

    swmf_cell #(
      .INDEX        (i),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .CW           (CW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (cc),
      .wr_en      (wr_any && (cnt_eff == CW'(i))),
      .wr_data    (smp),
      .next_value (nv),
      .next_probe (np),
      .head_probe (cell_probe[0]),
      .tick       (tick),
      .value      (cell_value[i]),
      .probe      (cell_probe[i]),
      .rank       (cell_rank[i])
    );
  end

endmodule

### tb/sliding_window_median_filter_unit_check.sv
// Checker for the sliding window median filter: watches the register and stream channels.
// It predicts each result and compares it with the output stream.
// Depends on swmf_pkg.
module sliding_window_median_filter_unit_check (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [swmf_pkg::CfgWidth-1:0] cfg_data,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [15:0]                   s_tdata,   // sample
  input  logic                          s_tlast,   // final_req
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [15:0]                   m_tdata,   // value
  input  logic                          m_tlast,   // end_of_run
  output int                            fail_count,
  output int                            due_count
);

  localparam int SW  = swmf_pkg::SampleWidthDef;
  localparam int MAX = swmf_pkg::MaxWindowDef;

  typedef struct {
    logic signed [SW-1:0] value;
    logic                 eor;
  } filt_result_t;

  filt_result_t                  results_due[$];
  logic signed [SW-1:0]          held [MAX];
  int unsigned                   fill;
  logic [swmf_pkg::CfgWidth-1:0] wsize;
  int                            errs;

  // Append one expected result at the tail of the queue
  function automatic void queue_result(input filt_result_t r);
    results_due.insert(results_due.size(), r);
  endfunction

  // Middle value of the n oldest held samples
  function automatic logic signed [SW-1:0] middle_of_window(int unsigned n);
    logic signed [SW-1:0] sorted [MAX];
    logic signed [SW-1:0] key;
    int                   j;
    for (int i = 0; i < n; i++) sorted[i] = held[i];
    for (int i = 1; i < n; i++) begin
      key = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > key) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    return sorted[(n - 1) / 2];
  endfunction

  // Advance the filter by one sample and queue the results it causes
  task automatic filter_step(input logic signed [SW-1:0] smp, input logic fin);
    int unsigned  w;
    int unsigned  cnt;
    int unsigned  first;
    filt_result_t r;
    w = wsize;
    if (w > MAX) w = MAX;
    first = results_due.size();
    if (w == 0 || (w % 2) == 0) begin
      // even window: pass the sample through
      fill = 0;
      r.value = smp;
      r.eor = 1'b1;
      queue_result(r);
    end else begin
      cnt = fill;
      if (cnt >= w) cnt = w - 1;
      held[cnt] = smp;
      cnt++;
      if (cnt == w) begin
        r.value = middle_of_window(w);
        r.eor = 1'b0;
        queue_result(r);
        for (int i = 1; i < cnt; i++) held[i-1] = held[i];
        cnt--;
      end
      // end of track: flush the held tail unchanged
      if (fin) begin
        for (int i = 0; i < cnt; i++) begin
          r.value = held[i];
          r.eor = 1'b0;
          queue_result(r);
        end
        cnt = 0;
      end
      fill = cnt;
      if (results_due.size() > first) begin
        r = results_due.pop_back();
        r.eor = 1'b1;
        queue_result(r);
      end
    end
  endtask

  always @(posedge clk) begin
    filt_result_t r;
    if (rst) begin
      results_due.delete();
      fill = 0;
      wsize = swmf_pkg::WindowReset;
      errs = 0;
    end else begin
      // register write drops the held samples
      if (cfg_valid && cfg_ready) begin
        wsize = cfg_data;
        fill = 0;
      end
      if (s_tvalid && s_tready) filter_step($signed(s_tdata[SW-1:0]), s_tlast);
      // compare each output transaction with the oldest expectation
      if (m_tvalid && m_tready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result value %0d end_of_run %0b", $time,
                   $signed(m_tdata[SW-1:0]), m_tlast);
          errs++;
        end else begin
          r = results_due.pop_front();
          if (m_tdata[SW-1:0] !== r.value) begin
            $display("%0t: value expected %0d, got %0d", $time, r.value,
                     $signed(m_tdata[SW-1:0]));
            errs++;
          end
          if (m_tlast !== r.eor) begin
            $display("%0t: end_of_run expected %0b, got %0b", $time, r.eor, m_tlast);
            errs++;
          end
        end
      end
    end
    fail_count <= errs;
    due_count <= results_due.size();
  end

endmodule

### tb/sliding_window_median_filter_unit_test.sv
// Testbench top for the sliding window median filter: clock, reset, stimulus, verdict.
// Depends on swmf_pkg, sliding_window_median_filter_unit and
// sliding_window_median_filter_unit_check.
module sliding_window_median_filter_unit_test;

  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE      = 48;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 27;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [swmf_pkg::CfgWidth-1:0] cfg_data = '0;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [15:0]                   s_tdata = '0;
  logic                          s_tlast = 1'b0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [15:0]                   m_tdata;
  logic                          m_tlast;

  int fail_count;
  int due_count;
  int quiet;
  int sender_pct = 0;
  int receiver_pct = 0;
  bit hold_ask = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  always #1 clk = ~clk;

  sliding_window_median_filter_unit uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  sliding_window_median_filter_unit_check chk (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .fail_count(fail_count),
    .due_count (due_count)
  );

  // Drive the result ready: long hold-off on request, else random stalls
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= receiver_pct);
    end
  end

  // End the run when no transaction moves for too long
  initial begin
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("sliding_window_median_filter_unit: mismatch");
    $finish;
  end

  // Offer one sample, with an optional idle gap first
  task automatic push_sample(input logic [15:0] smp, input logic fin);
    if ($urandom_range(99) < sender_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata <= smp;
    s_tlast <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Hold the input until every expected result has arrived
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
  endtask

  // Write the window size once the block has gone idle
  task automatic set_window(input logic [swmf_pkg::CfgWidth-1:0] w);
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mix of full-range, clustered, extreme and pitch-like values
  function automatic logic [15:0] rand_sample();
    logic [15:0] v;
    case ($urandom_range(3))
      0: v = 16'($urandom);
      1: v = 16'($urandom_range(0, 7)) - 16'd4;
      2: begin
        case ($urandom_range(3))
          0: v = 16'h7FFF;
          1: v = 16'h8000;
          2: v = 16'h0000;
          default: v = 16'hFFFF;
        endcase
      end
      default: v = 16'($urandom_range(0, 400));
    endcase
    return v;
  endfunction

  initial begin
    int unsigned phase_win [12] = '{3, 15, 7, 5, 1, 9, 2, 13, 11, 0, 15, 3};
    int unsigned w;
    int          left;
    int          len;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // window from reset: extremes, medians and a tail flush
    push_sample(16'h7FFF, 1'b0);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h0000, 1'b0);
    push_sample(16'h0001, 1'b0);
    push_sample(16'hFFFF, 1'b0);
    push_sample(16'd100, 1'b0);
    push_sample(16'hFF38, 1'b1);
    // short track ends before the window fills
    push_sample(16'd300, 1'b0);
    push_sample(16'hFED4, 1'b0);
    push_sample(16'd7, 1'b1);
    // rewrite drops a partial track; then a one-sample track
    set_window(4'd3);
    push_sample(16'd5, 1'b0);
    push_sample(16'd9, 1'b0);
    set_window(4'd3);
    push_sample(16'hFFFF, 1'b1);
    // window of one
    set_window(4'd1);
    push_sample(16'd42, 1'b0);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h7FFF, 1'b1);
    // even and zero windows pass through
    set_window(4'd4);
    push_sample(16'd11, 1'b0);
    push_sample(16'd12, 1'b1);
    set_window(4'd0);
    push_sample(16'd13, 1'b0);

    // random tracks over several windows and idling modes
    for (int p = 0; p < 12; p++) begin
      w = phase_win[p];
      set_window(w[swmf_pkg::CfgWidth-1:0]);
      case (p % 4)
        1: begin
          sender_pct = 74;
          receiver_pct = 0;
        end
        2: begin
          sender_pct = 0;
          receiver_pct = 74;
        end
        3: begin
          sender_pct = 16;
          receiver_pct = 16;
        end
        default: begin
          sender_pct = 0;
          receiver_pct = 0;
        end
      endcase
      if (p == 4) hold_ask = ~hold_ask;
      left = PHASE_ITEMS;
      while (left > 0) begin
        len = $urandom_range(1, 2 * w + 3);
        for (int k = 0; k < len && left > 0; k++) begin
          push_sample(rand_sample(), k == len - 1);
          left--;
        end
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && due_count == 0)
      $display("sliding_window_median_filter_unit: match");
    else
      $display("sliding_window_median_filter_unit: mismatch");
    $finish;
  end

endmodule

### sliding_window_median_filter_unit.f
hdl/swmf_pkg.sv
hdl/swmf_cell.sv
hdl/sliding_window_median_filter_unit.sv
tb/sliding_window_median_filter_unit_check.sv
tb/sliding_window_median_filter_unit_test.sv
